FILE: src/leq_pkg.sv
// Shared types and result codes for the latency emulation queue.
package leq_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_FETCH
  } state_t;

  localparam logic [1:0] RES_STORED = 2'd0;
  localparam logic [1:0] RES_FULL   = 2'd1;
  localparam logic [1:0] RES_DUP    = 2'd2;
  localparam logic [1:0] RES_FETCH  = 2'd3;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  typedef struct packed {
    logic capture;
    logic push_done;
    logic advance;
    logic fetch_done;
  } cmd_t;

  typedef struct packed {
    logic stale;
    logic out_free;
  } stat_t;

endpackage

FILE: src/leq_ctrl.sv
// Controller state machine for the latency emulation queue.
module leq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            action,
  input  leq_pkg::stat_t  stat,
  output leq_pkg::cmd_t   cmd
);

  leq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= leq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      leq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (action == leq_pkg::ACT_FETCH) ? leq_pkg::ST_FETCH
                                                       : leq_pkg::ST_PUSH;
        end
      end
      leq_pkg::ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push_done = 1'b1;
          state_next    = leq_pkg::ST_IDLE;
        end
      end
      leq_pkg::ST_FETCH: begin
        // drop one stale head per cycle, then report the head
        if (stat.stale) begin
          cmd.advance = 1'b1;
        end else if (stat.out_free) begin
          cmd.fetch_done = 1'b1;
          state_next     = leq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = leq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/leq_dp.sv
// Datapath: ring memories, pointers, age test and output register.
module leq_dp #(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  leq_pkg::cmd_t   cmd,
  output leq_pkg::stat_t  stat,
  input  logic [31:0]     stamp_ms,
  input  logic [31:0]     payload,
  input  logic            fresh,
  input  logic [15:0]     delay_ms,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status,
  output logic [31:0]     out_id,
  output logic [31:0]     out_stamp,
  output logic [31:0]     out_payload,
  output logic            out_fresh
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] pos);
    return (pos == AW'(DEPTH - 1)) ? '0 : pos + 1'b1;
  endfunction

  logic [31:0]   mem_stamp [DEPTH];
  logic [PW-1:0] mem_pay   [DEPTH];
  logic [31:0]   mem_id    [DEPTH];
  logic          mem_fresh [DEPTH];

  logic [31:0]   now;
  logic [15:0]   delay;
  logic [31:0]   pay;
  logic          fresh_in;

  logic [AW-1:0] head, tail;
  logic [31:0]   id_count;
  logic          zero_live;

  logic [AW-1:0] tail_nx, rd_addr;
  logic          full, store;
  logic [31:0]   rd_stamp, rd_id;
  logic [PW-1:0] rd_pay;
  logic          rd_fresh, rd_zero;
  logic [31:0]   h_stamp, h_id;
  logic [PW-1:0] h_pay;
  logic          h_fresh;
  logic [31:0]   age;
  logic          fresh_we;
  logic [AW-1:0] fresh_addr;

  assign tail_nx = ring_next(tail);
  assign full    = (tail_nx == head);
  assign store   = cmd.push_done && !full && fresh_in;

  // capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now      <= stamp_ms;
      delay    <= delay_ms;
      pay      <= payload;
      fresh_in <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      id_count  <= '0;
      zero_live <= 1'b1;
    end else begin
      if (cmd.advance) begin
        head <= ring_next(head);
      end
      if (store) begin
        tail     <= tail_nx;
        id_count <= id_count + 32'd1;
        if (tail_nx == '0) begin
          zero_live <= 1'b0;
        end
      end
    end
  end

  // stamp, payload and ID are written only by a store
  always_ff @(posedge clk) begin
    if (store) begin
      mem_stamp[tail_nx] <= now;
      mem_pay[tail_nx]   <= pay[PW-1:0];
      mem_id[tail_nx]    <= id_count + 32'd1;
    end
  end

  // a duplicate clears the newest flag, a store sets the new one
  assign fresh_we   = cmd.push_done && !full;
  assign fresh_addr = fresh_in ? tail_nx : tail;

  always_ff @(posedge clk) begin
    if (fresh_we) begin
      mem_fresh[fresh_addr] <= fresh_in;
    end
  end

  // read ahead at the next head so one entry drops per cycle
  assign rd_addr = cmd.advance ? ring_next(head) : head;

  always_ff @(posedge clk) begin
    rd_stamp <= mem_stamp[rd_addr];
    rd_pay   <= mem_pay[rd_addr];
    rd_id    <= mem_id[rd_addr];
    rd_fresh <= mem_fresh[rd_addr];
    rd_zero  <= zero_live && (rd_addr == '0);
  end

  // slot 0 holds the zeroed initial entry until a store overwrites it
  assign h_stamp = rd_zero ? '0 : rd_stamp;
  assign h_pay   = rd_zero ? '0 : rd_pay;
  assign h_id    = rd_zero ? '0 : rd_id;
  assign h_fresh = rd_zero ? 1'b0 : rd_fresh;

  assign age        = now - h_stamp;
  assign stat.stale = (head != tail) && !age[31] && (age[30:0] > 31'(delay));
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_done || cmd.fetch_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_done) begin
      status      <= full ? leq_pkg::RES_FULL
                          : (fresh_in ? leq_pkg::RES_STORED : leq_pkg::RES_DUP);
      out_id      <= '0;
      out_stamp   <= '0;
      out_payload <= '0;
      out_fresh   <= 1'b0;
    end else if (cmd.fetch_done) begin
      status      <= leq_pkg::RES_FETCH;
      out_id      <= h_id;
      out_stamp   <= h_stamp;
      out_payload <= 32'(h_pay);
      out_fresh   <= h_fresh;
    end
  end

`ifndef SYNTHESIS
  a_keep_last: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> head != tail)
    else $error("head advanced past the last entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_done || cmd.fetch_done) |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  a_store_grows: assert property (@(posedge clk) disable iff (rst)
    store |=> head != tail)
    else $error("queue empty after a store");

  a_fetch_fresh: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch_done |-> !stat.stale)
    else $error("fetch reported a stale head");
`endif

endmodule

FILE: src/latency_emulation_queue.sv
// Latency emulation queue: an accepted transaction is captured, then the
// push or fetch state registers the result once the output register is free;
// a fetch first drops stale heads one per cycle by the head pointer walk.
// A new transaction is taken only in idle; a held result adds stalls.
// Reset clears pointers, the ID counter and the output valid; the ring
// memories are not cleared, the zeroed slot 0 entry is flagged instead.
module latency_emulation_queue #(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] stamp_ms,
  input  logic [31:0] payload,
  input  logic        fresh,
  input  logic [15:0] delay_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] out_id,
  output logic [31:0] out_stamp,
  output logic [31:0] out_payload,
  output logic        out_fresh
);

  leq_pkg::cmd_t  cmd;
  leq_pkg::stat_t stat;

  leq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  leq_dp #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .stamp_ms    (stamp_ms),
    .payload     (payload),
    .fresh       (fresh),
    .delay_ms    (delay_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_id      (out_id),
    .out_stamp   (out_stamp),
    .out_payload (out_payload),
    .out_fresh   (out_fresh)
  );

endmodule
